// ===== src/smi_pkg.sv =====
// shared types and constants for the sorted merge intersection block
// used by smi_front, smi_fifo, smi_back and the top level
package smi_pkg;

  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 7;
  localparam int INDEX_W       = 6;
  localparam int CMD_W         = 2;
  localparam int S_DATA_W      = 40;
  localparam int M_DATA_W      = 40;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DEPTH_DEFAULT = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } smi_cmd_t;

  typedef struct packed {
    smi_cmd_t           cmd;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } smi_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } smi_q_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_CMP,
    B_FLUSH
  } smi_back_state_t;

endpackage

// ===== src/sorted_merge_intersection.sv =====
// loads: taken from the queue by the back end only while it is idle; a start walks both
// stores, each comparison a registered store read and then a compare, at most 2*n-1
// comparisons, then issues the final result; each match is held until the next match or the
// end of the walk; the command queue holds four words, so input stalls only when it is full
// reset: synchronous, clears queue, load pointers and output; store contents stay undefined
// top level of the sorted merge intersection block; depends on smi_pkg
module sorted_merge_intersection #(
  parameter int DEPTH = smi_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [smi_pkg::S_DATA_W-1:0] s_tdata,   // value[31:0], count[38:32], zero fill
  input  logic [smi_pkg::CMD_W-1:0]    s_tuser,   // command[1:0]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [smi_pkg::M_DATA_W-1:0] m_tdata,   // match_value[31:0], match_index[37:32], zero fill
  output logic                         m_tuser,   // none_found
  output logic                         m_tlast    // is_last
);
  import smi_pkg::*;

  smi_item_t          front_item;
  smi_item_t          back_item;
  smi_q_stat_t        q_stat;
  logic               push;
  logic               pop;
  logic [VALUE_W-1:0] out_value;
  logic [INDEX_W-1:0] out_index;

  smi_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .item     (front_item),
    .q_stat   (q_stat)
  );

  smi_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (back_item),
    .q_stat    (q_stat)
  );

  smi_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (back_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_index (out_index),
    .out_last  (m_tlast),
    .out_none  (m_tuser)
  );

  assign m_tdata = {(M_DATA_W - VALUE_W - INDEX_W)'(0), out_index, out_value};

endmodule

// ===== src/smi_front.sv =====
// front end: takes input words, decodes the command and queues valid ones
// depends on smi_pkg
module smi_front (
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [smi_pkg::S_DATA_W-1:0] s_tdata,   // value[31:0], count[38:32], zero fill
  input  logic [smi_pkg::CMD_W-1:0]   s_tuser,    // command[1:0]
  output logic                        push,
  output smi_pkg::smi_item_t          item,
  input  smi_pkg::smi_q_stat_t        q_stat
);
  import smi_pkg::*;

  logic known;

  always_comb begin
    item.value = s_tdata[VALUE_W-1:0];
    item.count = s_tdata[VALUE_W+COUNT_W-1:VALUE_W];
    known      = 1'b1;
    case (s_tuser)
      CMD_LOAD_A: item.cmd = CMD_LOAD_A;
      CMD_LOAD_B: item.cmd = CMD_LOAD_B;
      CMD_START:  item.cmd = CMD_START;
      default: begin
        // unused code: accepted and dropped
        item.cmd = CMD_START;
        known    = 1'b0;
      end
    endcase
  end

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready && known;

endmodule

// ===== src/smi_fifo.sv =====
// short command queue between front end and back end
// depends on smi_pkg
module smi_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  smi_pkg::smi_item_t   push_item,
  input  logic                 pop,
  output smi_pkg::smi_item_t   pop_item,
  output smi_pkg::smi_q_stat_t q_stat
);
  import smi_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  smi_item_t       q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [FW-1:0]   fill;
  logic            push_ok;
  logic            pop_ok;

  assign q_stat.full  = (fill == FW'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign push_ok      = push && !q_stat.full;
  assign pop_ok       = pop && !q_stat.empty;
  assign pop_item     = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_ok) wr_ptr <= wr_ptr + 1'b1;
      if (pop_ok)  rd_ptr <= rd_ptr + 1'b1;
      case ({push_ok, pop_ok})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/smi_back.sv =====
// back end: set stores, two-pointer merge walk and result register
// depends on smi_pkg
module smi_back #(
  parameter int DEPTH = smi_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  smi_pkg::smi_item_t          item,
  input  smi_pkg::smi_q_stat_t        q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [smi_pkg::VALUE_W-1:0] out_value,
  output logic [smi_pkg::INDEX_W-1:0] out_index,
  output logic                        out_last,
  output logic                        out_none
);
  import smi_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [VALUE_W-1:0] mem_a [DEPTH];
  logic [VALUE_W-1:0] mem_b [DEPTH];
  logic [VALUE_W-1:0] rd_a;
  logic [VALUE_W-1:0] rd_b;

  smi_back_state_t state, state_next;

  logic [CW-1:0] fill_a;
  logic [CW-1:0] fill_b;
  logic [CW-1:0] n;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [CW-1:0] i_next;
  logic [CW-1:0] j_next;
  logic [CW-1:0] n_start;

  logic               hold_valid;
  logic [VALUE_W-1:0] hold_value;
  logic [INDEX_W-1:0] hold_index;

  logic out_free;
  logic cmp_eq;
  logic cmp_lt;
  logic stall;
  logic advance;
  logic emit_mid;
  logic emit_end;
  logic do_load_a;
  logic do_load_b;
  logic do_start;

  assign out_free = !out_valid || out_ready;
  assign cmp_eq   = (rd_a == rd_b);
  assign cmp_lt   = ($signed(rd_a) < $signed(rd_b));
  assign n_start  = (item.count > COUNT_W'(DEPTH)) ? CW'(DEPTH) : CW'(item.count);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    do_load_a  = 1'b0;
    do_load_b  = 1'b0;
    do_start   = 1'b0;
    stall      = 1'b0;
    advance    = 1'b0;
    emit_mid   = 1'b0;
    emit_end   = 1'b0;
    i_next     = i;
    j_next     = j;
    case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (item.cmd)
            CMD_LOAD_A: do_load_a = 1'b1;
            CMD_LOAD_B: do_load_b = 1'b1;
            CMD_START: begin
              do_start   = 1'b1;
              state_next = (n_start == '0) ? B_FLUSH : B_READ;
            end
            default: ;
          endcase
        end
      end
      B_READ: state_next = B_CMP;
      B_CMP: begin
        // a new match pushes the held one out, so it needs the output slot
        stall   = cmp_eq && hold_valid && !out_free;
        advance = !stall;
        if (advance) begin
          emit_mid = cmp_eq && hold_valid;
          if (cmp_eq || cmp_lt)  i_next = i + 1'b1;
          if (cmp_eq || !cmp_lt) j_next = j + 1'b1;
          state_next = (i_next == n || j_next == n) ? B_FLUSH : B_READ;
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          emit_end   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // set stores, registered read
  always_ff @(posedge clk) begin
    if (do_load_a && fill_a < CW'(DEPTH)) begin
      mem_a[fill_a[AW-1:0]] <= item.value;
    end
    if (state == B_READ) begin
      rd_a <= mem_a[i[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (do_load_b && fill_b < CW'(DEPTH)) begin
      mem_b[fill_b[AW-1:0]] <= item.value;
    end
    if (state == B_READ) begin
      rd_b <= mem_b[j[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_a     <= '0;
      fill_b     <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (do_start) begin
        fill_a     <= '0;
        fill_b     <= '0;
        hold_valid <= 1'b0;
      end else begin
        if (do_load_a && fill_a < CW'(DEPTH)) fill_a <= fill_a + 1'b1;
        if (do_load_b && fill_b < CW'(DEPTH)) fill_b <= fill_b + 1'b1;
        if (advance && cmp_eq) hold_valid <= 1'b1;
        if (emit_end)          hold_valid <= 1'b0;
      end
      if (emit_mid || emit_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      n <= n_start;
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (advance) begin
      i <= i_next;
      j <= j_next;
      if (cmp_eq) begin
        k          <= k + 1'b1;
        hold_value <= rd_a;
        hold_index <= INDEX_W'(k);
      end
    end
    if (emit_mid) begin
      out_value <= hold_value;
      out_index <= hold_index;
      out_last  <= 1'b0;
      out_none  <= 1'b0;
    end else if (emit_end) begin
      out_value <= hold_valid ? hold_value : '0;
      out_index <= hold_valid ? hold_index : '0;
      out_last  <= 1'b1;
      out_none  <= !hold_valid;
    end
  end

`ifndef SYNTH
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_CMP) |-> (i < n && j < n))
    else $error("merge pointer past set length");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (fill_a <= CW'(DEPTH)) && (fill_b <= CW'(DEPTH)))
    else $error("load pointer past depth");

  a_none_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_none) |-> (out_last && out_value == '0 && out_index == '0))
    else $error("empty result not marked last or not zero");

  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    (state == B_FLUSH && out_free) |=> (state == B_IDLE && out_valid && out_last))
    else $error("final result not issued");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> !pop)
    else $error("queue popped during walk");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// testbench for sorted_merge_intersection: loads two sets, mostly sorted, starts merges and
// checks every match word against an in-bench two-pointer walk; depends on smi_pkg and the rtl
module tb;
  import smi_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 16;
  localparam int DRAIN_CYCLES = 300;
  localparam int SINK_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               is_last;
    logic               none_found;
  } match_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [CMD_W-1:0]    s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  // model of both stores and their load pointers
  logic [VALUE_W-1:0] mem_a [DEPTH];
  logic [VALUE_W-1:0] mem_b [DEPTH];
  int fill_a = 0;
  int fill_b = 0;
  // highest position ever written, so a start never reads an unwritten entry
  int hiwat_a = 0;
  int hiwat_b = 0;

  match_t pending_matches[$];
  int mismatches = 0;
  int cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int sink_hold = 0;
  int sink_gap = 0;

  sorted_merge_intersection #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void predict_matches(input logic [CMD_W-1:0] cmd,
                                          input logic [VALUE_W-1:0] val,
                                          input logic [COUNT_W-1:0] cnt);
    int n, i, j, k;
    match_t m;
    case (cmd)
      CMD_LOAD_A: begin
        if (fill_a < DEPTH) begin
          mem_a[fill_a] = val;
          fill_a++;
          if (fill_a > hiwat_a) hiwat_a = fill_a;
        end
      end
      CMD_LOAD_B: begin
        if (fill_b < DEPTH) begin
          mem_b[fill_b] = val;
          fill_b++;
          if (fill_b > hiwat_b) hiwat_b = fill_b;
        end
      end
      CMD_START: begin
        n = (cnt > DEPTH) ? DEPTH : cnt;
        i = 0;
        j = 0;
        k = 0;
        while (i < n && j < n) begin
          if (mem_a[i] == mem_b[j]) begin
            m.value = mem_a[i];
            m.index = k[INDEX_W-1:0];
            m.is_last = 1'b0;
            m.none_found = 1'b0;
            pending_matches.push_back(m);
            k++;
            i++;
            j++;
          end else if ($signed(mem_a[i]) < $signed(mem_b[j])) begin
            i++;
          end else begin
            j++;
          end
        end
        fill_a = 0;
        fill_b = 0;
        if (k == 0) begin
          m.value = '0;
          m.index = '0;
          m.is_last = 1'b1;
          m.none_found = 1'b1;
          pending_matches.push_back(m);
        end else begin
          m = pending_matches.pop_back();
          m.is_last = 1'b1;
          pending_matches.push_back(m);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                           input logic [COUNT_W-1:0] cnt);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {1'b0, cnt, val};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_matches(cmd, val, cnt);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // ascending run starting just above base; a base near the top wraps and breaks the order
  task automatic load_run(input logic [CMD_W-1:0] cmd, input int n, input int base,
                          input int max_step);
    int v;
    v = base;
    for (int k = 0; k < n; k++) begin
      v = v + $urandom_range(1, max_step);
      send_word(cmd, v, COUNT_W'($urandom_range(0, 127)));
    end
  endtask

  task automatic wait_drained();
    while (pending_matches.size() != 0) @(negedge clk);
  endtask

  // receiver: random stall bursts, plus a long hold when a test asks for one
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_tready = 1'b0;
      sink_hold--;
    end else if (sink_gap > 0) begin
      m_tready = 1'b0;
      sink_gap--;
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      m_tready = 1'b0;
      sink_gap = $urandom_range(0, 6);
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    match_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual value=%0d index=%0d last=%b none=%b",
                 $time, $signed(m_tdata[VALUE_W-1:0]), m_tdata[VALUE_W +: INDEX_W],
                 m_tlast, m_tuser);
        mismatches++;
      end else begin
        want = pending_matches.pop_front();
        if (m_tdata[VALUE_W-1:0] !== want.value) begin
          $display("%0t: match_value expected %0d actual %0d", $time,
                   $signed(want.value), $signed(m_tdata[VALUE_W-1:0]));
          mismatches++;
        end
        if (m_tdata[VALUE_W +: INDEX_W] !== want.index) begin
          $display("%0t: match_index expected %0d actual %0d", $time,
                   want.index, m_tdata[VALUE_W +: INDEX_W]);
          mismatches++;
        end
        if (m_tlast !== want.is_last) begin
          $display("%0t: is_last expected %b actual %b", $time, want.is_last, m_tlast);
          mismatches++;
        end
        if (m_tuser !== want.none_found) begin
          $display("%0t: none_found expected %b actual %b", $time, want.none_found, m_tuser);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed();
    // matches at both ends of the signed range
    send_word(CMD_LOAD_A, 32'h8000_0000, 7'd0);
    send_word(CMD_LOAD_A, 32'hFFFF_FFFF, 7'd127);
    send_word(CMD_LOAD_A, 32'h0000_0000, 7'd0);
    send_word(CMD_LOAD_A, 32'h7FFF_FFFF, 7'd0);
    send_word(CMD_LOAD_B, 32'h8000_0000, 7'd0);
    send_word(CMD_LOAD_B, 32'h0000_0000, 7'd0);
    send_word(CMD_LOAD_B, 32'h0000_0001, 7'd0);
    send_word(CMD_LOAD_B, 32'h7FFF_FFFF, 7'd0);
    send_word(CMD_NOP, 32'h1234_5678, 7'd5);
    send_word(CMD_START, 32'hFFFF_FFFF, 7'd4);
    // count zero finds nothing
    send_word(CMD_START, 32'h0000_0000, 7'd0);
    // disjoint sets
    send_word(CMD_LOAD_A, -32'sd3, 7'd0);
    send_word(CMD_LOAD_A, 32'sd5, 7'd0);
    send_word(CMD_LOAD_B, -32'sd2, 7'd0);
    send_word(CMD_LOAD_B, 32'sd6, 7'd0);
    send_word(CMD_START, 32'h0, 7'd2);
    // only position 0 is fresh, the rest still hold earlier rounds
    send_word(CMD_LOAD_A, 32'hFFFF_FFFF, 7'd0);
    send_word(CMD_LOAD_B, 32'hFFFF_FFFF, 7'd0);
    send_word(CMD_START, 32'h0, 7'd4);
    // unsorted sets go through the same walk
    send_word(CMD_LOAD_A, 32'sd9, 7'd0);
    send_word(CMD_LOAD_A, 32'sd2, 7'd0);
    send_word(CMD_LOAD_A, 32'sd7, 7'd0);
    send_word(CMD_LOAD_B, 32'sd2, 7'd0);
    send_word(CMD_LOAD_B, 32'sd9, 7'd0);
    send_word(CMD_LOAD_B, 32'sd7, 7'd0);
    send_word(CMD_START, 32'h0, 7'd3);
  endtask

  task automatic test_full_store();
    logic [VALUE_W-1:0] vals [DEPTH];
    int v;
    v = -int'($urandom_range(0, 50000));
    for (int k = 0; k < DEPTH; k++) begin
      v = v + $urandom_range(1, 1000);
      vals[k] = v;
    end
    // first set filled past depth; the extra loads are dropped
    for (int k = 0; k < DEPTH + 2; k++)
      send_word(CMD_LOAD_A, (k < DEPTH) ? vals[k] : $urandom,
                COUNT_W'($urandom_range(0, 127)));
    // matches at the first, middle and last position, so only the first set is walked
    // to its end and the count saturates
    send_word(CMD_LOAD_B, vals[0], COUNT_W'($urandom_range(0, 127)));
    send_word(CMD_LOAD_B, vals[DEPTH/2], COUNT_W'($urandom_range(0, 127)));
    send_word(CMD_LOAD_B, vals[DEPTH-1], COUNT_W'($urandom_range(0, 127)));
    send_word(CMD_START, $urandom, 7'd127);
  endtask

  // receiver stops for a long time while loads and starts keep coming
  task automatic test_sink_hold();
    int base;
    base = $urandom;
    sink_hold = SINK_HOLD_CYCLES;
    load_run(CMD_LOAD_A, 5, base, 2);
    load_run(CMD_LOAD_B, 5, base, 2);
    send_word(CMD_START, $urandom, 7'd5);
    send_word(CMD_START, $urandom, 7'd0);
    load_run(CMD_LOAD_A, 3, base, 1);
    load_run(CMD_LOAD_B, 3, base, 1);
    send_word(CMD_START, $urandom, 7'd3);
  endtask

  // sender waits for the block to go quiet before the next start
  task automatic test_drain_pause();
    wait_drained();
    send_word(CMD_START, $urandom, 7'd4);
    wait_drained();
    load_run(CMD_LOAD_A, 3, -7, 2);
    load_run(CMD_LOAD_B, 3, -7, 2);
    send_word(CMD_START, $urandom, 7'd3);
    wait_drained();
  endtask

  task automatic test_random();
    int sent, na, nb, base, step, lim, cnt;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // quiet final stretch
      if (sent > RANDOM_ITEMS * 3 / 4) begin
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
      end
      na = $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) na = $urandom_range(9, 24);
      nb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : na;
      base = $urandom;
      step = $urandom_range(1, 4);
      load_run(CMD_LOAD_A, na, base, step);
      load_run(CMD_LOAD_B, nb, base, step);
      sent += na + nb;
      if ($urandom_range(0, 7) == 0)
        send_word(CMD_NOP, $urandom, COUNT_W'($urandom_range(0, 127)));
      // stray small value breaks the order of one set
      if ($urandom_range(0, 7) == 0) begin
        send_word(($urandom_range(0, 1) == 0) ? CMD_LOAD_A : CMD_LOAD_B,
                  $urandom_range(0, 7), COUNT_W'($urandom_range(0, 127)));
        sent++;
      end
      lim = (hiwat_a < hiwat_b) ? hiwat_a : hiwat_b;
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = $urandom_range(0, lim);
        2: cnt = (lim == DEPTH) ? $urandom_range(DEPTH, 127) : lim;
        default: cnt = (na < nb) ? na : nb;
      endcase
      send_word(CMD_START, $urandom, cnt[COUNT_W-1:0]);
      sent++;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    rst = 1'b1;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_store();
    test_sink_hold();
    test_drain_pause();
    test_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
